// File: sv/assert_macros.svh
// Assertion macros shared by the rational arithmetic unit modules.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau assertion failed");

`else

`define RAU_ASSERT_IMPL(lbl, ante, cons)
`define RAU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
// No dependencies; imported by the datapath, the controller and the top level.
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;                 // operand bits actually used
	localparam int IN_FIELD_W    = 32;                 // width of each operand field
	localparam int WORK_W        = 2 * OPERAND_WIDTH;  // product / GCD / divider width
	localparam int SHIFT_W       = $clog2(WORK_W);     // GCD power-of-two count
	localparam int CNT_W         = $clog2(WORK_W);     // divider step counter
	localparam int EXT_W         = 64;                 // width for saturation
	localparam int RES_NUM_W     = 63;
	localparam int RES_DEN_W     = 62;
	localparam int S_TDATA_W     = 4 * IN_FIELD_W;
	localparam int M_TDATA_W     = 128;
	localparam int S_TUSER_W     = 2;

	localparam logic [EXT_W-1:0] MAG_LIMIT = {2'b00, {(EXT_W-2){1'b1}}};

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} rau_op_t;

	// which product the shared multiplier forms this cycle
	typedef enum logic [1:0] {
		MS_NUM   = 2'd0,
		MS_CROSS = 2'd1,
		MS_DEN   = 2'd2
	} rau_mstep_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_COMB,
		ST_CHECK,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} rau_state_t;

	typedef struct packed {
		logic       capture;
		logic       mul_en;
		rau_mstep_t mul_step;
		logic       combine;
		logic       gcd_load;
		logic       gcd_step;
		logic       div_load;
		logic       div_step;
		logic       out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic gcd_done;
	} rau_status_t;

endpackage

// File: sv/rau_datapath.sv
// Datapath: operand capture, shared multiplier, signed sum, binary GCD,
// two restoring dividers and the output register. Depends on rau_pkg.
`include "assert_macros.svh"

module rau_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rau_pkg::rau_cmd_t                  cmd,
	output rau_pkg::rau_status_t               status,
	input  logic [rau_pkg::S_TUSER_W-1:0]      op_in,
	input  logic [rau_pkg::IN_FIELD_W-1:0]     a_num,
	input  logic [rau_pkg::IN_FIELD_W-1:0]     a_den,
	input  logic [rau_pkg::IN_FIELD_W-1:0]     b_num,
	input  logic [rau_pkg::IN_FIELD_W-1:0]     b_den,
	output logic [rau_pkg::RES_NUM_W-1:0]      res_num,
	output logic [rau_pkg::RES_DEN_W-1:0]      res_den,
	output logic                               zero_den_error
);
	import rau_pkg::*;

	function automatic logic [OPERAND_WIDTH-1:0] op_mag(input logic [OPERAND_WIDTH-1:0] v);
		op_mag = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// captured operands as magnitude and sign
	rau_op_t                  op_q;
	logic [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic                     an_s_q, ad_s_q, bn_s_q, bd_s_q;

	// products
	logic [WORK_W-1:0] p_mag_q, q_mag_q, den_mag_q;
	logic              p_neg_q, q_neg_q, den_neg_q;

	// combined numerator
	logic [WORK_W-1:0] num_mag_q;
	logic              num_neg_q;
	logic              den_zero_q, num_zero_q;

	// GCD and dividers
	logic [WORK_W-1:0]  u_q, v_q;
	logic [SHIFT_W-1:0] k_q;
	logic [WORK_W-1:0]  g_q;
	logic [WORK_W-1:0]  rn_q, rd_q, qn_q, qd_q;

	// output register
	logic [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0] res_den_q;
	logic                 err_q;

	// multiplier operand select
	logic [OPERAND_WIDTH-1:0] mx, my;
	logic                     mxs, mys;
	logic [WORK_W-1:0]        prod;
	logic                     prod_neg;

	always_comb begin
		mx  = an_q;
		mxs = an_s_q;
		my  = bd_q;
		mys = bd_s_q;
		case (cmd.mul_step)
			MS_NUM: begin
				mx  = an_q;
				mxs = an_s_q;
				if (op_q == OP_MUL) begin
					my  = bn_q;
					mys = bn_s_q;
				end else begin
					my  = bd_q;
					mys = bd_s_q;
				end
			end
			MS_CROSS: begin
				mx  = bn_q;
				mxs = bn_s_q;
				my  = ad_q;
				mys = ad_s_q;
			end
			MS_DEN: begin
				mx  = ad_q;
				mxs = ad_s_q;
				if (op_q == OP_DIV) begin
					my  = bn_q;
					mys = bn_s_q;
				end else begin
					my  = bd_q;
					mys = bd_s_q;
				end
			end
			default: begin
				mx  = an_q;
				mxs = an_s_q;
				my  = bd_q;
				mys = bd_s_q;
			end
		endcase
		prod     = WORK_W'(mx) * WORK_W'(my);
		prod_neg = (mxs ^ mys) && (prod != '0);
	end

	// signed sum of the two cross products
	logic [WORK_W-1:0] sum_mag;
	logic              sum_neg;
	logic              is_addsub;

	always_comb begin
		is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
		if (p_neg_q == q_neg_q) begin
			sum_mag = p_mag_q + q_mag_q;
			sum_neg = p_neg_q;
		end else if (p_mag_q >= q_mag_q) begin
			sum_mag = p_mag_q - q_mag_q;
			sum_neg = p_neg_q;
		end else begin
			sum_mag = q_mag_q - p_mag_q;
			sum_neg = q_neg_q;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	// binary GCD step
	logic gcd_done;
	assign gcd_done = (u_q == '0) || (v_q == '0);

	// restoring divide step, both dividers share the divisor
	logic [WORK_W:0] tn, td;
	logic            gen, ged;

	always_comb begin
		tn  = {rn_q, qn_q[WORK_W-1]};
		td  = {rd_q, qd_q[WORK_W-1]};
		gen = tn >= {1'b0, g_q};
		ged = td >= {1'b0, g_q};
	end

	// result formatting
	logic [EXT_W-1:0] nm_ext, dm_ext, nm_sat, dm_sat, nm_neg;
	logic             res_neg;

	always_comb begin
		nm_ext  = EXT_W'(qn_q);
		dm_ext  = EXT_W'(qd_q);
		nm_sat  = (nm_ext > MAG_LIMIT) ? MAG_LIMIT : nm_ext;
		dm_sat  = (dm_ext > MAG_LIMIT) ? MAG_LIMIT : dm_ext;
		nm_neg  = ~nm_sat + 1'b1;
		res_neg = num_neg_q ^ den_neg_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= rau_op_t'(op_in);
			an_q   <= op_mag(a_num[OPERAND_WIDTH-1:0]);
			ad_q   <= op_mag(a_den[OPERAND_WIDTH-1:0]);
			bn_q   <= op_mag(b_num[OPERAND_WIDTH-1:0]);
			bd_q   <= op_mag(b_den[OPERAND_WIDTH-1:0]);
			an_s_q <= a_num[OPERAND_WIDTH-1];
			ad_s_q <= a_den[OPERAND_WIDTH-1];
			bn_s_q <= b_num[OPERAND_WIDTH-1];
			bd_s_q <= b_den[OPERAND_WIDTH-1];
		end

		if (cmd.mul_en) begin
			case (cmd.mul_step)
				MS_NUM: begin
					p_mag_q <= prod;
					p_neg_q <= prod_neg;
				end
				MS_CROSS: begin
					q_mag_q <= prod;
					// subtract: negate the second term
					q_neg_q <= prod_neg ^ ((op_q == OP_SUB) && (prod != '0));
				end
				MS_DEN: begin
					den_mag_q <= prod;
					den_neg_q <= prod_neg;
				end
				default: begin
					p_mag_q <= prod;
					p_neg_q <= prod_neg;
				end
			endcase
		end

		if (cmd.combine) begin
			num_mag_q  <= is_addsub ? sum_mag : p_mag_q;
			num_neg_q  <= is_addsub ? sum_neg : p_neg_q;
			num_zero_q <= is_addsub ? (sum_mag == '0) : (p_mag_q == '0);
			den_zero_q <= den_mag_q == '0;
		end

		if (cmd.gcd_load) begin
			u_q <= num_mag_q;
			v_q <= den_mag_q;
			k_q <= '0;
		end else if (cmd.gcd_step && !gcd_done) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end

		if (cmd.div_load) begin
			g_q  <= (u_q | v_q) << k_q;
			rn_q <= '0;
			rd_q <= '0;
			qn_q <= num_mag_q;
			qd_q <= den_mag_q;
		end else if (cmd.div_step) begin
			rn_q <= gen ? WORK_W'(tn - {1'b0, g_q}) : tn[WORK_W-1:0];
			rd_q <= ged ? WORK_W'(td - {1'b0, g_q}) : td[WORK_W-1:0];
			qn_q <= {qn_q[WORK_W-2:0], gen};
			qd_q <= {qd_q[WORK_W-2:0], ged};
		end

		if (cmd.out_load) begin
			if (den_zero_q) begin
				res_num_q <= '0;
				res_den_q <= '0;
				err_q     <= 1'b1;
			end else if (num_zero_q) begin
				res_num_q <= '0;
				res_den_q <= RES_DEN_W'(1);
				err_q     <= 1'b0;
			end else begin
				res_num_q <= res_neg ? nm_neg[RES_NUM_W-1:0] : nm_sat[RES_NUM_W-1:0];
				res_den_q <= dm_sat[RES_DEN_W-1:0];
				err_q     <= 1'b0;
			end
		end
	end

	assign status.den_zero = den_zero_q;
	assign status.num_zero = num_zero_q;
	assign status.gcd_done = gcd_done;

	assign res_num        = res_num_q;
	assign res_den        = res_den_q;
	assign zero_den_error = err_q;

	// both GCD operands start nonzero, otherwise the zero checks would skip it
	`RAU_ASSERT_NEXT(a_gcd_start_nonzero, cmd.gcd_load, (u_q != '0) && (v_q != '0))
	// divisor for the reduction is never zero
	`RAU_ASSERT_NEXT(a_div_nonzero, cmd.div_load, g_q != '0)
	// denominator is zero exactly on error
	`RAU_ASSERT_NEXT(a_err_den, cmd.out_load, (res_den_q == '0) == err_q)

endmodule

// File: sv/rau_controller.sv
// Controller state machine: sequences capture, products, GCD and division,
// and owns the stream handshakes. Depends on rau_pkg.
`include "assert_macros.svh"

module rau_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output rau_pkg::rau_cmd_t     cmd,
	input  rau_pkg::rau_status_t  status
);
	import rau_pkg::*;

	rau_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             m_tvalid_q, m_tvalid_d;
	logic             out_free;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORK_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		cmd.mul_step = MS_NUM;
		s_tready   = 1'b0;
		m_tvalid_d = m_tvalid_q && !m_tready;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_NUM;
				state_d      = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_CROSS;
				state_d      = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_DEN;
				state_d      = ST_COMB;
			end
			ST_COMB: begin
				cmd.combine = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.den_zero || status.num_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.gcd_load = 1'b1;
					state_d      = ST_GCD;
				end
			end
			ST_GCD: begin
				if (status.gcd_done) begin
					cmd.div_load = 1'b1;
					cnt_d        = '0;
					state_d      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

	// a waiting result is never overwritten
	`RAU_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid_q || m_tready)
	// divider runs exactly WORK_W steps
	`RAU_ASSERT_NEXT(a_div_len, (state_q == ST_DIV) && (cnt_q == CNT_LAST), state_q == ST_DONE)
	// zero numerator or denominator bypasses the reduction
	`RAU_ASSERT_NEXT(a_bypass, (state_q == ST_CHECK) && (status.den_zero || status.num_zero),
		state_q == ST_DONE)

endmodule

// File: sv/rational_arithmetic_unit_top.sv
// Rational arithmetic unit, top level: stream ports, controller and datapath.
// Depends on rau_pkg, rau_controller and rau_datapath.
//
// Usage:
//   Input requests arrive on the s_ group: s_tuser carries the operation
//   (add, subtract, multiply, divide), s_tdata the two signed fractions.
//   A request is taken when s_tvalid and s_tready are both high.
//   The reduced fraction leaves on the m_ group; m_tuser flags a zero
//   result denominator, in which case both numerator and denominator are 0.
// Sequencing:
//   One request is worked on at a time. Capture, three products on the
//   single 32x32 multiplier, the signed sum and the zero checks come first.
//   Binary GCD then takes one step per cycle; the two restoring dividers
//   follow, then the output load. A zero numerator or denominator skips
//   the GCD and the division and goes straight to the output load.
// Reset and stalls:
//   arst_n clears the controller and the output valid; no result is pending.
//   A result waits in the output register until m_tready; meanwhile the next
//   request is taken and worked on, and waits at its end for the register.
module rational_arithmetic_unit_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
	input  logic [rau_pkg::S_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [rau_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_num[62:0], res_den[124:63], zero fill [127:125]
	output logic [rau_pkg::M_TDATA_W-1:0]  m_tdata,
	// zero_den_error
	output logic                           m_tuser
);
	import rau_pkg::*;

	rau_cmd_t    cmd;
	rau_status_t status;

	logic [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;

	rau_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	rau_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.op_in          (s_tuser),
		.a_num          (s_tdata[IN_FIELD_W-1:0]),
		.a_den          (s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]),
		.b_num          (s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]),
		.b_den          (s_tdata[4*IN_FIELD_W-1:3*IN_FIELD_W]),
		.res_num        (res_num),
		.res_den        (res_den),
		.zero_den_error (m_tuser)
	);

	// payload packed from the lowest bit, zero filled to whole bytes
	assign m_tdata = {{(M_TDATA_W-RES_NUM_W-RES_DEN_W){1'b0}}, res_den, res_num};

endmodule

// File: tb/rau_checker.sv
// Stream checker for the rational arithmetic unit: computes the reduced fraction for
// every accepted request and compares it with the next result on the m_ group.
// Depends on rau_pkg for the operation codes and the operand widths.
module rau_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [rau_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [rau_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [rau_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          m_tuser,
	output int                            mismatches,
	output int                            pending,
	output int                            checked,
	output int                            zero_den_seen,
	output int                            saturated
);
	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	typedef struct {
		logic [63:0] mag;
		logic        neg;
	} sign_mag_t;

	typedef struct {
		logic [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0] den;
		logic                 zde;
		logic                 sat;
	} fraction_t;

	fraction_t expected_fractions[$];
	int n_mismatch = 0;
	int n_pending  = 0;
	int n_checked  = 0;
	int n_zde      = 0;
	int n_sat      = 0;

	assign mismatches    = n_mismatch;
	assign pending       = n_pending;
	assign checked       = n_checked;
	assign zero_den_seen = n_zde;
	assign saturated     = n_sat;

	// low OPERAND_WIDTH bits as a two's complement value, split into magnitude and sign
	function automatic sign_mag_t split_operand(logic [IN_FIELD_W-1:0] raw);
		logic [OPERAND_WIDTH-1:0] v;
		logic [OPERAND_WIDTH-1:0] v_abs;
		sign_mag_t r;
		v     = raw[OPERAND_WIDTH-1:0];
		v_abs = ~v + 1'b1;
		r.neg = v[OPERAND_WIDTH-1];
		r.mag = r.neg ? 64'(v_abs) : 64'(v);
		return r;
	endfunction

	function automatic sign_mag_t mul_sm(sign_mag_t x, sign_mag_t y);
		sign_mag_t r;
		r.mag = x.mag * y.mag;
		r.neg = (r.mag != 0) && (x.neg != y.neg);
		return r;
	endfunction

	function automatic sign_mag_t add_sm(sign_mag_t x, sign_mag_t y);
		sign_mag_t r;
		if (x.neg == y.neg) begin
			r.mag = x.mag + y.mag;
			r.neg = x.neg;
		end else if (x.mag >= y.mag) begin
			r.mag = x.mag - y.mag;
			r.neg = x.neg;
		end else begin
			r.mag = y.mag - x.mag;
			r.neg = y.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] euclid_gcd(logic [63:0] m, logic [63:0] n);
		logic [63:0] t;
		while (n != 0) begin
			t = m % n;
			m = n;
			n = t;
		end
		return m;
	endfunction

	function automatic fraction_t predict_fraction(rau_op_t op, logic [S_TDATA_W-1:0] d);
		sign_mag_t an, ad, bn, bd, p, q, num, den;
		logic [63:0] g, nm, dm;
		fraction_t r;
		an = split_operand(d[0*IN_FIELD_W +: IN_FIELD_W]);
		ad = split_operand(d[1*IN_FIELD_W +: IN_FIELD_W]);
		bn = split_operand(d[2*IN_FIELD_W +: IN_FIELD_W]);
		bd = split_operand(d[3*IN_FIELD_W +: IN_FIELD_W]);
		case (op)
			OP_ADD, OP_SUB: begin
				p = mul_sm(an, bd);
				q = mul_sm(bn, ad);
				if (op == OP_SUB && q.mag != 0)
					q.neg = !q.neg;
				num = add_sm(p, q);
				den = mul_sm(ad, bd);
			end
			OP_MUL: begin
				num = mul_sm(an, bn);
				den = mul_sm(ad, bd);
			end
			default: begin
				num = mul_sm(an, bd);
				den = mul_sm(ad, bn);
			end
		endcase
		r.num = '0;
		r.den = '0;
		r.zde = 1'b0;
		r.sat = 1'b0;
		// zero denominator wins over a zero numerator
		if (den.mag == 0) begin
			r.zde = 1'b1;
			return r;
		end
		if (num.mag == 0) begin
			r.den = RES_DEN_W'(1);
			return r;
		end
		g  = euclid_gcd(num.mag, den.mag);
		nm = num.mag / g;
		dm = den.mag / g;
		if (nm > MAG_LIMIT) begin
			nm    = MAG_LIMIT;
			r.sat = 1'b1;
		end
		if (dm > MAG_LIMIT) begin
			dm    = MAG_LIMIT;
			r.sat = 1'b1;
		end
		if (num.neg != den.neg)
			nm = ~nm + 64'd1;
		r.num = nm[RES_NUM_W-1:0];
		r.den = dm[RES_DEN_W-1:0];
		return r;
	endfunction

	// sampled at the edge, so everything seen here is the value from before the edge
	always @(posedge clk) begin
		fraction_t exp_f;
		logic [RES_NUM_W-1:0] got_num;
		logic [RES_DEN_W-1:0] got_den;
		logic [M_TDATA_W-RES_NUM_W-RES_DEN_W-1:0] got_pad;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_num = m_tdata[RES_NUM_W-1:0];
				got_den = m_tdata[RES_NUM_W +: RES_DEN_W];
				got_pad = m_tdata[M_TDATA_W-1:RES_NUM_W+RES_DEN_W];
				if (expected_fractions.size() == 0) begin
					$error("unexpected result: res_num %0d, res_den %0d, zero_den_error %0b",
						$signed(got_num), got_den, m_tuser);
					n_mismatch++;
				end else begin
					exp_f = expected_fractions.pop_front();
					n_checked++;
					if (m_tuser)
						n_zde++;
					if (got_num !== exp_f.num) begin
						$error("res_num mismatch: expected %0d, actual %0d",
							$signed(exp_f.num), $signed(got_num));
						n_mismatch++;
					end
					if (got_den !== exp_f.den) begin
						$error("res_den mismatch: expected %0d, actual %0d", exp_f.den, got_den);
						n_mismatch++;
					end
					if (m_tuser !== exp_f.zde) begin
						$error("zero_den_error mismatch: expected %0b, actual %0b",
							exp_f.zde, m_tuser);
						n_mismatch++;
					end
					if (got_pad !== '0) begin
						$error("tdata zero fill mismatch: expected 0, actual %0h", got_pad);
						n_mismatch++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				exp_f = predict_fraction(rau_op_t'(s_tuser), s_tdata);
				if (exp_f.sat)
					n_sat++;
				expected_fractions.push_back(exp_f);
			end
			n_pending = expected_fractions.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top for the rational arithmetic unit: clock, reset, request stimulus
// and result back-pressure. Depends on rau_pkg, rau_checker and the unit's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	// covers GCD and division plus the longest gap on each side for every request,
	// with a wide margin over the whole run
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int RANDOM_COUNT = 1550;
	localparam int DRAIN_CYCLES = 400;

	// operand corner values
	localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [31:0] MAX_NEG = 32'h8000_0001;
	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // a_num, a_den, b_num, b_den from bit 0 up
	logic [S_TUSER_W-1:0]  s_tuser;   // op
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // res_num, res_den, zero fill from bit 0 up
	logic                  m_tuser;   // zero_den_error

	int  mismatches, pending, checked, zero_den_seen, saturated;
	int  requests_sent = 0;
	int  directed_sent = 0;
	int  cycles = 0;
	bit  calm = 1'b0;   // while set neither side idles

	rational_arithmetic_unit_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rau_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.zero_den_seen (zero_den_seen),
		.saturated     (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycles, pending);
		$display("tb_top NOT OK");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	// operand mix: zeros and corner values now and then, many small values so
	// reductions cancel a lot, and full 32-bit patterns so every bit toggles
	function automatic logic [31:0] pick_operand();
		int unsigned r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 9) begin
			case ($urandom_range(0, 4))
				0:       return 32'd1;
				1:       return MINUS_ONE;
				2:       return MAX_POS;
				3:       return MAX_NEG;
				default: return MOST_NEG;
			endcase
		end
		if (r < 45)
			v = $urandom_range(1, 60);
		else if (r < 65)
			v = $urandom_range(1, 100000);
		else
			return $urandom();
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// result side: ready with random stalls, none while calm
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && !calm)
				stall_left = gap_len();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one request: hold valid until taken, then maybe idle with junk on the bus
	task automatic send_request(input rau_op_t op, input logic [31:0] an, input logic [31:0] ad,
			input logic [31:0] bn, input logic [31:0] bd);
		int gap;
		s_tuser  <= op;
		s_tdata  <= {bd, bn, ad, an};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom(), $urandom(), $urandom(), $urandom()};
			s_tuser  <= S_TUSER_W'($urandom_range(0, 3));
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		rau_op_t     op;
		logic [31:0] an, ad, bn, bd;
		int unsigned k;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_ADD;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain cases for each operation
		send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);          // cancels to 0/1
		send_request(OP_MUL, 32'd3, 32'd4, -32'd2, 32'd3);
		send_request(OP_DIV, 32'd1, 32'd2, 32'd3, 32'd4);
		send_request(OP_DIV, 32'd5, 32'd7, -32'd10, 32'd21);
		// negative denominators must come out positive
		send_request(OP_ADD, 32'd1, -32'd2, 32'd1, -32'd3);
		send_request(OP_SUB, MINUS_ONE, MINUS_ONE, 32'd1, MINUS_ONE);
		// zero denominators: from either input and from dividing by zero
		send_request(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd3);
		send_request(OP_MUL, 32'd4, 32'd5, 32'd1, 32'd0);
		send_request(OP_DIV, 32'd4, 32'd5, 32'd0, 32'd9);
		// zero over zero: the error wins over the zero numerator
		send_request(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
		// zero numerator with a good denominator
		send_request(OP_MUL, 32'd0, 32'd5, 32'd3, 32'd7);
		send_request(OP_SUB, 32'd0, -32'd5, 32'd0, 32'd7);
		// full-scale operands
		send_request(OP_ADD, MAX_POS, 32'd1, MAX_POS, 32'd1);
		send_request(OP_MUL, MAX_POS, 32'd1, MAX_NEG, 32'd1);
		send_request(OP_DIV, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
		send_request(OP_SUB, MAX_POS, MAX_NEG, MAX_NEG, MAX_POS);
		// most negative value: numerator and denominator saturation
		send_request(OP_MUL, MOST_NEG, 32'd1, MOST_NEG, 32'd1);
		send_request(OP_MUL, 32'd1, MOST_NEG, 32'd1, MOST_NEG);
		send_request(OP_ADD, MOST_NEG, MAX_POS, MOST_NEG, MAX_POS - 32'd2);
		send_request(OP_DIV, MOST_NEG, 32'd3, MOST_NEG, 32'd3);
		send_request(OP_SUB, MOST_NEG, MOST_NEG, MOST_NEG, 32'd1);
		directed_sent = requests_sent;

		// random: a quiet stretch at the end of every 250 requests
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			calm = (i % 250) >= 200;
			op = rau_op_t'($urandom_range(0, 3));
			an = pick_operand();
			ad = pick_operand();
			if ($urandom_range(0, 4) == 0) begin
				// second fraction the first with both terms scaled by a small factor: large common factors
				k  = $urandom_range(1, 40);
				bn = an * k;
				bd = ad * ($urandom_range(0, 1) ? k : -k);
			end else begin
				bn = pick_operand();
				bd = pick_operand();
			end
			send_request(op, an, ad, bn, bd);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		// let the checker log the last request before waiting on the count
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d directed, all four operations), %0d results checked",
			requests_sent, directed_sent, checked);
		$display("%0d zero-denominator errors and %0d saturated results among them",
			zero_den_seen, saturated);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_datapath.sv
sv/rau_controller.sv
sv/rational_arithmetic_unit_top.sv
tb/rau_checker.sv
tb/tb_top.sv
